// ----- rtl/cstg_pkg.sv -----
// Shared types and constants for the CAN signal to gauge step mapper.
package cstg_pkg;

   localparam int unsigned FULL_SCALE_DEFAULT = 9000;
   localparam int unsigned QUEUE_DEPTH        = 4;

   localparam int unsigned ID_W    = 29;
   localparam int unsigned LEN_W   = 4;
   localparam int unsigned DATA_W  = 64;
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned STEP_W  = 12;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned FRAME_BYTES = 8;

   typedef enum logic [INDEX_W-1:0] {
      REG_ENABLE     = 3'd0,
      REG_MATCH_ID   = 3'd1,
      REG_START_BYTE = 3'd2,
      REG_WIDE_VALUE = 3'd3,
      REG_SCALE_Q    = 3'd4,
      REG_OFFSET_Q   = 3'd5,
      REG_ZERO_STEP  = 3'd6,
      REG_FULL_STEP  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic              enable;
      logic [ID_W-1:0]   match_id;
      logic [2:0]        start_byte;
      logic              wide_value;
      logic [31:0]       scale_q;
      logic [31:0]       offset_q;
      logic [STEP_W-1:0] zero_step;
      logic [STEP_W-1:0] full_step;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [RAW_W-1:0] raw;
   } slot_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- rtl/cstg_front.sv -----
// Front end: accepts frames, matches the identifier and extracts the raw signal.
module cstg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  cstg_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cstg_pkg::ID_W-1:0]           req_frame_id,
   input  logic [cstg_pkg::LEN_W-1:0]          req_frame_len,
   input  logic [cstg_pkg::DATA_W-1:0]         req_payload,
   input  cstg_pkg::queue_status_type          q_status,
   output cstg_pkg::slot_type                  push
);
   import cstg_pkg::*;

   logic             slot_valid_ff;
   logic             slot_valid_in;
   logic [RAW_W-1:0] slot_raw_ff;
   logic [RAW_W-1:0] slot_raw_in;
   logic             accept;
   logic             match;
   logic             advance;
   logic [LEN_W-1:0] len_clip;
   logic [2:0]       hi_index;
   logic [LEN_W-1:0] lo_need;
   logic [LEN_W-1:0] hi_need;
   logic [7:0]       lo_byte;
   logic [7:0]       hi_byte;

   assign req_stall = slot_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign match     = cfg.enable && (req_frame_id == cfg.match_id);
   assign advance   = !slot_valid_ff || !q_status.full;

   always_comb begin
      len_clip = (req_frame_len > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) : req_frame_len;
      hi_index = cfg.start_byte + 3'd1;
      lo_need  = {1'b0, cfg.start_byte};
      hi_need  = {1'b0, cfg.start_byte} + LEN_W'(1);
      lo_byte  = req_payload[{cfg.start_byte, 3'b000} +: 8];
      hi_byte  = req_payload[{hi_index, 3'b000} +: 8];
      if (lo_need >= len_clip) begin
         slot_raw_in = '0;
      end else if (!cfg.wide_value) begin
         slot_raw_in = {8'd0, lo_byte};
      end else if (hi_need >= len_clip) begin
         slot_raw_in = '0;
      end else begin
         slot_raw_in = {hi_byte, lo_byte};
      end
      slot_valid_in = accept && match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_raw_ff <= slot_raw_in;
      end
   end

   assign push.valid = slot_valid_ff && !q_status.full;
   assign push.raw   = slot_raw_ff;

endmodule

// ----- rtl/cstg_fifo.sv -----
// Short queue of raw values between the front end and the arithmetic pipeline.
module cstg_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  cstg_pkg::slot_type                push,
   input  logic                              pop,
   output cstg_pkg::queue_status_type        q_status,
   output logic [cstg_pkg::RAW_W-1:0]        head_raw
);
   import cstg_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [RAW_W-1:0] store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.raw;
      end
   end

   assign head_raw       = store_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count missed a push");

endmodule

// ----- rtl/cstg_back.sv -----
// Back end: gain, offset, clamp and round, then linear map onto the needle steps.
module cstg_back #(
   parameter int unsigned FULL_SCALE = cstg_pkg::FULL_SCALE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cstg_pkg::cfg_type                  cfg,
   input  cstg_pkg::queue_status_type         q_status,
   input  logic [cstg_pkg::RAW_W-1:0]         head_raw,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cstg_pkg::STEP_W-1:0]        rsp_target_step,
   output logic [cstg_pkg::VALUE_W-1:0]       rsp_gauge_value
);
   import cstg_pkg::*;

   localparam int unsigned ACC_W   = 49;
   localparam int unsigned M_W     = STEP_W + VALUE_W;
   localparam int unsigned SHIFT   = M_W + $clog2(FULL_SCALE);
   localparam int unsigned RECIP_W = M_W + 1;
   localparam int unsigned QM_W    = M_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
   localparam logic signed [ACC_W-1:0] TOP = ACC_W'(64'(FULL_SCALE) << 16);

   logic                      advance;
   logic [4:0]                stage_valid_ff;
   logic [4:0]                stage_valid_in;
   logic                      rsp_valid_ff;

   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [VALUE_W-1:0]        value3_ff, value3_in;
   logic                      neg3_ff, neg3_in;
   logic [STEP_W-1:0]         mag3_ff, mag3_in;
   logic [VALUE_W-1:0]        value4_ff;
   logic                      neg4_ff;
   logic [M_W-1:0]            m_ff, m_in;
   logic [VALUE_W-1:0]        value5_ff;
   logic                      neg5_ff;
   logic [QM_W-1:0]           qm_ff, qm_in;
   logic [STEP_W-1:0]         quot;
   logic [STEP_W-1:0]         target_in;
   logic [STEP_W-1:0]         target_ff;
   logic [VALUE_W-1:0]        gauge_ff;
   logic [32:0]               rounded;
   logic [STEP_W-1:0]         step_lo;
   logic [STEP_W-1:0]         step_hi;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !q_status.empty;

   always_comb begin
      stage_valid_in = {stage_valid_ff[3:0], pop};

      prod_in = ACC_W'($signed({1'b0, head_raw})) * ACC_W'($signed(cfg.scale_q));
      acc_in  = prod_ff + ACC_W'($signed(cfg.offset_q));

      rounded = {1'b0, acc_ff[31:0]} + 33'h0_0000_8000;
      if (acc_ff[ACC_W-1]) begin
         value3_in = '0;
      end else if (acc_ff >= TOP) begin
         value3_in = VALUE_W'(FULL_SCALE);
      end else begin
         value3_in = rounded[31:16];
      end
      neg3_in = cfg.full_step < cfg.zero_step;
      mag3_in = neg3_in ? cfg.zero_step - cfg.full_step : cfg.full_step - cfg.zero_step;

      m_in  = M_W'(mag3_ff) * M_W'(value3_ff);
      qm_in = QM_W'(m_ff) * QM_W'(RECIP);

      quot      = STEP_W'(qm_ff >> SHIFT);
      target_in = neg5_ff ? cfg.zero_step - quot : cfg.zero_step + quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= stage_valid_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         acc_ff    <= acc_in;
         value3_ff <= value3_in;
         neg3_ff   <= neg3_in;
         mag3_ff   <= mag3_in;
         m_ff      <= m_in;
         value4_ff <= value3_ff;
         neg4_ff   <= neg3_ff;
         qm_ff     <= qm_in;
         value5_ff <= value4_ff;
         neg5_ff   <= neg4_ff;
         target_ff <= target_in;
         gauge_ff  <= value5_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_step = target_ff;
   assign rsp_gauge_value = gauge_ff;

   assign step_lo = (cfg.full_step < cfg.zero_step) ? cfg.full_step : cfg.zero_step;
   assign step_hi = (cfg.full_step < cfg.zero_step) ? cfg.zero_step : cfg.full_step;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (gauge_ff <= VALUE_W'(FULL_SCALE)))
      else $error("gauge value above full scale");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((target_ff >= step_lo) && (target_ff <= step_hi)))
      else $error("target step outside the needle span");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(target_ff) && $stable(gauge_ff)))
      else $error("stalled result changed");

endmodule

// ----- rtl/can_signal_to_gauge_step.sv -----
// Top level of the CAN signal to gauge step mapper: configuration registers and wiring.
//
// Each frame whose identifier matches an enabled channel gives one result: the raw byte or
// little-endian byte pair times a Q16.16 gain plus offset, clamped to 0..FULL_SCALE and rounded
// half up (gauge_value), and the needle step between zero_step and full_step for that value,
// truncated toward zero (target_step). Other frames give no result. One frame is taken every
// clock cycle while req_stall is low; a matching frame's result passes through one front register,
// the queue, and a six-register back pipeline built around three multipliers (gain, then span
// times value followed by a reciprocal multiply for the division by FULL_SCALE). A four-entry
// queue lets the front keep taking frames while rsp_stall holds the back. Registers are written
// through the csr_ port, which is always ready; the user must write them only while no frame is
// in flight, which the block itself does not enforce.
module can_signal_to_gauge_step #(
   parameter int unsigned FULL_SCALE = cstg_pkg::FULL_SCALE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cstg_pkg::ID_W-1:0]          req_frame_id,
   input  logic [cstg_pkg::LEN_W-1:0]         req_frame_len,
   input  logic [cstg_pkg::DATA_W-1:0]        req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cstg_pkg::STEP_W-1:0]        rsp_target_step,
   output logic [cstg_pkg::VALUE_W-1:0]       rsp_gauge_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cstg_pkg::INDEX_W-1:0]       csr_index,
   input  logic [cstg_pkg::CSR_W-1:0]         csr_data
);
   import cstg_pkg::*;

   cfg_type          cfg_ff;
   queue_status_type q_status;
   slot_type         push;
   logic             pop;
   logic [RAW_W-1:0] head_raw;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b0;
         cfg_ff.match_id   <= '0;
         cfg_ff.start_byte <= '0;
         cfg_ff.wide_value <= 1'b0;
         cfg_ff.scale_q    <= 32'h0001_0000;
         cfg_ff.offset_q   <= '0;
         cfg_ff.zero_step  <= 12'd50;
         cfg_ff.full_step  <= 12'd1150;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_ENABLE:     cfg_ff.enable     <= csr_data[0];
            REG_MATCH_ID:   cfg_ff.match_id   <= csr_data[ID_W-1:0];
            REG_START_BYTE: cfg_ff.start_byte <= csr_data[2:0];
            REG_WIDE_VALUE: cfg_ff.wide_value <= csr_data[0];
            REG_SCALE_Q:    cfg_ff.scale_q    <= csr_data;
            REG_OFFSET_Q:   cfg_ff.offset_q   <= csr_data;
            REG_ZERO_STEP:  cfg_ff.zero_step  <= csr_data[STEP_W-1:0];
            REG_FULL_STEP:  cfg_ff.full_step  <= csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cstg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_frame_id  (req_frame_id),
      .req_frame_len (req_frame_len),
      .req_payload   (req_payload),
      .q_status      (q_status),
      .push          (push)
   );

   cstg_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .q_status (q_status),
      .head_raw (head_raw)
   );

   cstg_back #(
      .FULL_SCALE (FULL_SCALE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_status        (q_status),
      .head_raw        (head_raw),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_target_step (rsp_target_step),
      .rsp_gauge_value (rsp_gauge_value)
   );

endmodule
